/* hdl/rsps_pkg.sv */
// ============================================================================
// rsps_pkg
// Shared widths, hash constants and controller/datapath interface types for
// the sign random projection sketch.
// ============================================================================
package rsps_pkg;

    // Field and counter widths
    localparam int SAMPLE_W    = 16;  // Q1.15 sample
    localparam int SB_W        = 5;   // sign_bytes register
    localparam int BYTE_CAP    = 16;  // most sign bytes per sketch
    localparam int CNT_W       = 8;   // load count, holds up to 128
    localparam int IDX_W       = 7;   // element / sketch index, 0..127
    localparam int BIDX_W      = 4;   // byte index, 0..15
    localparam int BIT_W       = 3;   // bit position within a byte
    localparam int ACC_W       = 24;  // exact projection sum
    localparam int HASH_W      = 32;
    localparam int MIX_W       = 17;  // low hash bits that reach the sign
    localparam int OUT_TDATA_W = 16;
    localparam int DEF_MAX_DIM = 128;
    localparam int SB_RESET    = 16;

    // Hash multipliers
    localparam logic [HASH_W-1:0] HASH_MUL_D  = 32'd2654435761;
    localparam logic [HASH_W-1:0] HASH_MUL_S  = 32'd340573321;
    localparam logic [HASH_W-1:0] HASH_MIX    = 32'h045D9F3B;
    localparam logic [MIX_W-1:0]  HASH_MIX_LO = HASH_MIX[MIX_W-1:0];

    // Commands from the controller to the datapath
    typedef struct packed {
        logic              wr_en;      // store one sample
        logic [IDX_W-1:0]  wr_idx;
        logic              rd_en;      // read one element for the projection
        logic [IDX_W-1:0]  rd_idx;
        logic              rd_last;    // final element of this projection
        logic              first_proj; // sketch index back to zero
        logic              next_proj;  // advance to the next sketch index
        logic              emit;       // load the output register
        logic [BIDX_W-1:0] emit_idx;
        logic              emit_last;
    } rsps_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic proj_done; // one projection finished, its bit is in the byte
        logic out_free;  // output register can take a new request
    } rsps_status_t;

endpackage

/* hdl/rsps_ram.sv */
// ============================================================================
// rsps_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module rsps_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hdl/rsps_ctrl.sv */
// ============================================================================
// rsps_ctrl
// Sketch controller: holds the byte-count register, counts samples in, then
// sequences element reads, projections and byte hand-off to the datapath.
// ============================================================================
module rsps_ctrl
    import rsps_pkg::*;
#(
    parameter int MAX_DIM = DEF_MAX_DIM
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wen,
    input  logic [SB_W-1:0]   cfg_wdata,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  rsps_status_t      status,
    output rsps_cmd_t         cmd
);

    localparam int BYTE_LIM = ((MAX_DIM / 8) > BYTE_CAP) ? BYTE_CAP : (MAX_DIM / 8);

    typedef enum logic [3:0] {
        ST_LOAD  = 4'b0001,
        ST_RUN   = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [SB_W-1:0]    sb_reg, sb_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [IDX_W-1:0]   d_reg, d_next;
    logic [BIT_W-1:0]   k_reg, k_next;
    logic [BIDX_W-1:0]  b_reg, b_next;

    logic [SB_W-1:0]    nbytes;
    logic [CNT_W-1:0]   dim;
    logic [IDX_W-1:0]   dim_m1;
    logic [BIDX_W-1:0]  last_b;
    logic [IDX_W-1:0]   load_idx;
    logic [CNT_W-1:0]   cnt_inc;
    logic               accept;

    // Effective byte count: zero acts as one, large values clamp to the bound.
    always_comb begin
        if (sb_reg == '0) begin
            nbytes = SB_W'(1);
        end else if (sb_reg > SB_W'(BYTE_LIM)) begin
            nbytes = SB_W'(BYTE_LIM);
        end else begin
            nbytes = sb_reg;
        end
    end

    assign dim     = CNT_W'({nbytes, 3'b000});
    assign dim_m1  = IDX_W'(dim - CNT_W'(1));
    assign last_b  = BIDX_W'(nbytes - SB_W'(1));

    // Sample slot for the incoming request.
    assign load_idx = (cnt_reg >= dim) ? '0 : cnt_reg[IDX_W-1:0];
    assign cnt_inc  = CNT_W'(load_idx) + CNT_W'(1);

    // A register write takes the cycle, so no request is taken alongside it.
    assign s_tready = (state_reg == ST_LOAD) && !cfg_wen;
    assign accept   = s_tvalid && s_tready;

    // Next-state and command logic.
    always_comb begin
        state_next = state_reg;
        sb_next    = sb_reg;
        cnt_next   = cnt_reg;
        d_next     = d_reg;
        k_next     = k_reg;
        b_next     = b_reg;
        cmd        = '0;
        cmd.wr_idx   = load_idx;
        cmd.rd_idx   = d_reg;
        cmd.rd_last  = (d_reg == dim_m1);
        cmd.emit_idx = b_reg;
        cmd.emit_last = (b_reg == last_b);

        case (state_reg)
            ST_LOAD: begin
                if (cfg_wen) begin
                    sb_next  = cfg_wdata;
                    cnt_next = '0;
                end else if (accept) begin
                    cmd.wr_en = 1'b1;
                    if (cnt_inc == dim) begin
                        cnt_next       = '0;
                        cmd.first_proj = 1'b1;
                        d_next         = '0;
                        k_next         = '0;
                        b_next         = '0;
                        state_next     = ST_RUN;
                    end else begin
                        cnt_next = cnt_inc;
                    end
                end
            end
            ST_RUN: begin
                cmd.rd_en = 1'b1;
                if (d_reg == dim_m1) begin
                    d_next     = '0;
                    state_next = ST_DRAIN;
                end else begin
                    d_next = d_reg + IDX_W'(1);
                end
            end
            ST_DRAIN: begin
                if (status.proj_done) begin
                    if (k_reg == '1) begin
                        k_next     = '0;
                        state_next = ST_EMIT;
                    end else begin
                        k_next        = k_reg + BIT_W'(1);
                        cmd.next_proj = 1'b1;
                        state_next    = ST_RUN;
                    end
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (b_reg == last_b) begin
                        state_next = ST_LOAD;
                    end else begin
                        b_next        = b_reg + BIDX_W'(1);
                        cmd.next_proj = 1'b1;
                        state_next    = ST_RUN;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            sb_reg    <= SB_W'(SB_RESET);
            cnt_reg   <= '0;
            d_reg     <= '0;
            k_reg     <= '0;
            b_reg     <= '0;
        end else begin
            state_reg <= state_next;
            sb_reg    <= sb_next;
            cnt_reg   <= cnt_next;
            d_reg     <= d_next;
            k_reg     <= k_next;
            b_reg     <= b_next;
        end
    end

endmodule

/* hdl/rsps_dpath.sv */
// ============================================================================
// rsps_dpath
// Sketch datapath: sample store, hashed sign pipeline, projection
// accumulator, sign byte assembly and the output register.
// ============================================================================
module rsps_dpath
    import rsps_pkg::*;
#(
    parameter int MAX_DIM = DEF_MAX_DIM
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  rsps_cmd_t                     cmd,
    input  logic signed [SAMPLE_W-1:0]    sample,
    output rsps_status_t                  status,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic [OUT_TDATA_W-1:0]        m_tdata,
    output logic                          m_tlast
);

    localparam int AW = $clog2(MAX_DIM);

    logic [HASH_W-1:0]          da_reg;     // d * HASH_MUL_D
    logic [HASH_W-1:0]          sb_reg;     // s * HASH_MUL_S
    logic [HASH_W-1:0]          h;
    logic [MIX_W-1:0]           hmix_reg;
    logic [MIX_W-1:0]           prod_reg;
    logic                       v1_reg, l1_reg, v2_reg, l2_reg;
    logic [SAMPLE_W-1:0]        rdata;
    logic signed [SAMPLE_W-1:0] x_reg;
    logic signed [ACC_W-1:0]    acc_reg, acc_sum, x_ext;
    logic                       sign_pos;
    logic [7:0]                 byte_reg;
    logic                       out_valid_reg;
    logic [7:0]                 out_byte_reg;
    logic [BIDX_W-1:0]          out_idx_reg;
    logic                       out_last_reg;

    // Sample store.
    rsps_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_DIM)
    ) u_store (
        .aclk  (aclk),
        .we    (cmd.wr_en),
        .waddr (AW'(cmd.wr_idx)),
        .wdata (sample),
        .re    (cmd.rd_en),
        .raddr (AW'(cmd.rd_idx)),
        .rdata (rdata)
    );

    // Stage 0: hash input, the index products kept as running sums.
    assign h = da_reg + sb_reg;

    always_ff @(posedge aclk) begin
        if (cmd.first_proj) begin
            sb_reg <= '0;
            da_reg <= '0;
        end else if (cmd.next_proj) begin
            sb_reg <= sb_reg + HASH_MUL_S;
            da_reg <= '0;
        end else if (cmd.rd_en) begin
            da_reg <= da_reg + HASH_MUL_D;
        end
        if (cmd.rd_en) begin
            hmix_reg <= {h[16], h[15:0] ^ h[31:16]};
        end
        // Stage 1: mixing multiply on the low bits, sample arrives.
        prod_reg <= MIX_W'(hmix_reg * HASH_MIX_LO);
        x_reg    <= $signed(rdata);
    end

    // Stage 2: the sign is bit 0 of the mixed hash after the final fold.
    assign sign_pos = prod_reg[0] ^ prod_reg[16];
    assign x_ext    = ACC_W'(x_reg);
    assign acc_sum  = sign_pos ? (acc_reg + x_ext) : (acc_reg - x_ext);

    assign status.proj_done = v2_reg && l2_reg;
    assign status.out_free  = !out_valid_reg || m_tready;

    // Pipeline valids, accumulator and byte assembly.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg  <= 1'b0;
            l1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            l2_reg  <= 1'b0;
            acc_reg <= '0;
        end else begin
            v1_reg <= cmd.rd_en;
            l1_reg <= cmd.rd_en && cmd.rd_last;
            v2_reg <= v1_reg;
            l2_reg <= l1_reg;
            if (v2_reg) begin
                acc_reg <= l2_reg ? '0 : acc_sum;
            end
        end
    end

    // First projection of a byte ends up in bit 0 after eight shifts.
    always_ff @(posedge aclk) begin
        if (status.proj_done) begin
            byte_reg <= {~acc_sum[ACC_W-1], byte_reg[7:1]};
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_byte_reg <= byte_reg;
            out_idx_reg  <= cmd.emit_idx;
            out_last_reg <= cmd.emit_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'({out_idx_reg, out_byte_reg});
    assign m_tlast  = out_last_reg;

endmodule

/* hdl/random_sign_projection_sketch_top.sv */
// ============================================================================
// random_sign_projection_sketch_top
// Loads a vector of Q1.15 samples and returns its sign random projection
// sketch as bytes of sign bits, least significant bit first.
// ============================================================================
//
//  Channel  Dir  Signals                   Contents
//  s_       in   s_tvalid/tready/tdata     [15:0] sample
//  m_       out  m_tvalid/tready/tdata     [7:0] sign_byte, [11:8] byte_index
//                m_tlast                   final byte of the sketch
//  cfg_     in   cfg_wen/cfg_wdata         sign_bytes (N = 8 * sign_bytes)
//
//  Samples are taken one per cycle while loading, except in a register write cycle.
//  After the last sample, each of the N projections reads the sample store
//  once per element and passes the two-stage sign pipeline, and each byte
//  then enters the output register; no new samples are taken until the
//  last byte of the sketch has entered it.
//  Reset is synchronous and active low; the sample store is not cleared.
//  A stalled output register holds the next byte's hand-off and the projections after it.
//
module random_sign_projection_sketch_top
    import rsps_pkg::*;
#(
    parameter int MAX_DIM = DEF_MAX_DIM
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wen,
    input  logic [SB_W-1:0]             cfg_wdata,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic signed [SAMPLE_W-1:0]  s_tdata,   // [15:0] sample
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata,   // [7:0] sign_byte, [11:8] byte_index
    output logic                        m_tlast
);

    rsps_cmd_t    cmd;
    rsps_status_t status;

    // Controller.
    rsps_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath.
    rsps_dpath #(
        .MAX_DIM (MAX_DIM)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sample   (s_tdata),
        .status   (status),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // A byte is handed to the output register only when it can take it.
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> status.out_free)
        else $error("byte emitted into a busy output register");

    // No sample request is taken while projections read the store.
    a_no_load_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_en |-> !s_tready)
        else $error("input ready during projection");

    // The final element read finishes its projection once it reaches stage 2.
    a_proj_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.rd_en && cmd.rd_last) |-> ##2 status.proj_done)
        else $error("projection did not complete on time");

    // After the last byte of a sketch the block is ready for samples.
    a_back_to_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && cmd.emit_last) |=> (s_tready || cfg_wen))
        else $error("not ready for samples after the final byte");

endmodule
